@@ design/nfa_pkg.sv @@
// Shared types, codes and sizes for the NOR flash array model.
package nfa_pkg;

  // Store geometry: 1 MiB of 16-bit words
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned BYTE_ADDR_W = 20;
  localparam int unsigned WORD_ADDR_W = 19;
  localparam int unsigned STORE_WORDS = 524288;
  localparam longint unsigned STORE_BYTES = 64'd1048576;

  localparam logic [DATA_W-1:0] ERASED_WORD = '1;

  // Parameter defaults for the top level
  localparam int unsigned SECTOR_BYTES_DEF = 65536;
  localparam int unsigned SECTOR_COUNT_DEF = 16;

  // Action codes
  localparam logic [1:0] ACT_READ      = 2'd0;
  localparam logic [1:0] ACT_PROGRAM   = 2'd1;
  localparam logic [1:0] ACT_ERASE_SEC = 2'd2;
  localparam logic [1:0] ACT_ERASE_ALL = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ODD    = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_SECTOR = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_SWEEP,
    S_POST
  } state_t;

  typedef enum logic [1:0] {
    K_RMW,
    K_SWEEP,
    K_FLAG
  } kind_t;

  // Request from the sequencer to the word memory
  typedef struct packed {
    logic                   we;
    logic [WORD_ADDR_W-1:0] waddr;
    logic [DATA_W-1:0]      wdata;
    logic                   re;
    logic [WORD_ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ design/nor_flash_array_model_top.sv @@
// Top level of the NOR flash array model: sequencer plus word store.
//
// Input channel (in_*): one transfer per item carrying action, byte address,
// sector number and write data. The item is taken at a clock edge where
// in_valid is high and in_stall is low. Output channel (out_*): exactly one
// transfer per item with read_data and status.
//
// Read and program: the word is read from the store at the input transfer;
// in the next cycle a program merges it and writes it back, and the result
// goes to the output register, or waits in the sequencer while that register
// is held. Flagged items pass through the post state to the output register.
// Erase: one word is written per cycle; a sector erase writes SECTOR_BYTES/2
// words, clipped to the store, and a chip erase (array bytes)/2 words.
// One item is in work at a time; in_stall stays high until its result is
// in the output register.
// Reset: rst_n is synchronous, active low. After reset the store is cleared
// to zeros by a pass over all 524288 words, one word per cycle, during which
// in_stall is high.
// Receiver stall: a result waits in the output register while out_stall is
// high; a finished read or program waits in the sequencer until it drains.
module nor_flash_array_model_top #(
  parameter int unsigned SECTOR_BYTES = nfa_pkg::SECTOR_BYTES_DEF,
  parameter int unsigned SECTOR_COUNT = nfa_pkg::SECTOR_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [nfa_pkg::BYTE_ADDR_W-1:0]  in_byte_address,
  input  logic [5:0]                       in_sector_number,
  input  logic [nfa_pkg::DATA_W-1:0]       in_write_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [nfa_pkg::DATA_W-1:0]       out_read_data,
  output logic [1:0]                       out_status
);

  // Request to the store and the word it returns, registered in the store
  nfa_pkg::mem_req_t          mem_req;
  logic [nfa_pkg::DATA_W-1:0] mem_rdata;

  nfa_ctrl #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .SECTOR_COUNT (SECTOR_COUNT)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_byte_address  (in_byte_address),
    .in_sector_number (in_sector_number),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_status       (out_status),
    .mem_req          (mem_req),
    .mem_rdata        (mem_rdata)
  );

  // Hold all 524288 words; written by the clear pass, erases and programs
  nfa_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

@@ design/nfa_mem.sv @@
// Word store: one write port, one read port with registered read data.
module nfa_mem (
  input  logic                        clk,
  input  nfa_pkg::mem_req_t           req,
  output logic [nfa_pkg::DATA_W-1:0]  rdata
);

  logic [nfa_pkg::DATA_W-1:0] mem_q [nfa_pkg::STORE_WORDS];
  logic [nfa_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_q[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem_q[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/nfa_ctrl.sv @@
// Sequencer: decode, read-modify-write, erase sweeps, clear pass, result register.
module nfa_ctrl #(
  parameter int unsigned SECTOR_BYTES = nfa_pkg::SECTOR_BYTES_DEF,
  parameter int unsigned SECTOR_COUNT = nfa_pkg::SECTOR_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [nfa_pkg::BYTE_ADDR_W-1:0]  in_byte_address,
  input  logic [5:0]                       in_sector_number,
  input  logic [nfa_pkg::DATA_W-1:0]       in_write_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [nfa_pkg::DATA_W-1:0]       out_read_data,
  output logic [1:0]                       out_status,
  output nfa_pkg::mem_req_t                mem_req,
  input  logic [nfa_pkg::DATA_W-1:0]       mem_rdata
);

  localparam int unsigned BA_W = nfa_pkg::BYTE_ADDR_W;
  localparam int unsigned WA_W = nfa_pkg::WORD_ADDR_W;
  localparam int unsigned DW   = nfa_pkg::DATA_W;

  // Array span in bytes, clipped to the store
  localparam longint unsigned ARRAY_RAW =
    longint'(SECTOR_BYTES) * longint'(SECTOR_COUNT);
  localparam longint unsigned ARRAY_CLIP =
    (ARRAY_RAW > nfa_pkg::STORE_BYTES) ? nfa_pkg::STORE_BYTES : ARRAY_RAW;
  localparam logic [BA_W:0]   ARRAY_BYTES = (BA_W+1)'(ARRAY_CLIP);
  localparam logic [BA_W:0]   ALL_END     = (BA_W+1)'(ARRAY_CLIP >> 1);
  localparam logic [BA_W:0]   STORE_END   = (BA_W+1)'(nfa_pkg::STORE_WORDS);
  localparam logic [BA_W+7:0] SB_L        = (BA_W+8)'(SECTOR_BYTES);
  localparam logic [BA_W+7:0] STORE_B_L   = (BA_W+8)'(nfa_pkg::STORE_BYTES);
  localparam logic [6:0]      SC_L        = 7'(SECTOR_COUNT);

  nfa_pkg::state_t state_r, state_nxt;

  logic [BA_W:0]   ptr_r, ptr_nxt;
  logic [BA_W:0]   end_r, end_nxt;
  logic [DW-1:0]   fill_r, fill_nxt;
  logic [1:0]      act_r, act_nxt;
  logic [DW-1:0]   wdata_r, wdata_nxt;
  logic [WA_W-1:0] waddr_r, waddr_nxt;
  logic [DW-1:0]   res_data_r, res_data_nxt;
  logic [1:0]      res_status_r, res_status_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [DW-1:0]   out_data_r, out_data_nxt;
  logic [1:0]      out_status_r, out_status_nxt;

  // Decode of the incoming item
  nfa_pkg::kind_t  dec_kind;
  logic [1:0]      dec_status;
  logic [BA_W:0]   dec_start;
  logic [BA_W:0]   dec_end;
  logic [BA_W+7:0] sec_lo;
  logic [BA_W+7:0] sec_hi;
  logic [BA_W+7:0] sec_hi_clip;

  logic out_free;
  logic sweep_last;

  assign out_free   = !out_valid_r || !out_stall;
  assign sweep_last = ((ptr_r + 1'b1) == end_r);

  always_comb begin
    sec_lo      = (BA_W+8)'(in_sector_number) * SB_L;
    sec_hi      = sec_lo + SB_L;
    sec_hi_clip = (sec_hi > STORE_B_L) ? STORE_B_L : sec_hi;
    dec_kind    = nfa_pkg::K_FLAG;
    dec_status  = nfa_pkg::ST_OK;
    dec_start   = '0;
    dec_end     = '0;
    case (in_action)
      nfa_pkg::ACT_READ, nfa_pkg::ACT_PROGRAM: begin
        if (in_byte_address[0]) begin
          dec_status = nfa_pkg::ST_ODD;
        end else if ({1'b0, in_byte_address} >= ARRAY_BYTES) begin
          dec_status = nfa_pkg::ST_RANGE;
        end else begin
          dec_kind = nfa_pkg::K_RMW;
        end
      end
      nfa_pkg::ACT_ERASE_SEC: begin
        if ({1'b0, in_sector_number} >= SC_L) begin
          dec_status = nfa_pkg::ST_SECTOR;
        end else if (sec_lo < STORE_B_L) begin
          // sector starts inside the store: sweep its words, clipped
          dec_kind  = nfa_pkg::K_SWEEP;
          dec_start = (BA_W+1)'(sec_lo >> 1);
          dec_end   = (BA_W+1)'(sec_hi_clip >> 1);
        end
      end
      nfa_pkg::ACT_ERASE_ALL: begin
        dec_kind  = nfa_pkg::K_SWEEP;
        dec_start = '0;
        dec_end   = ALL_END;
      end
      default: begin
        dec_kind = nfa_pkg::K_FLAG;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nfa_pkg::S_CLEAR: begin
        if (ptr_r == STORE_END - 1'b1) state_nxt = nfa_pkg::S_IDLE;
      end
      nfa_pkg::S_IDLE: begin
        if (in_valid) begin
          case (dec_kind)
            nfa_pkg::K_RMW:   state_nxt = nfa_pkg::S_RMW;
            nfa_pkg::K_SWEEP: state_nxt = nfa_pkg::S_SWEEP;
            default:          state_nxt = nfa_pkg::S_POST;
          endcase
        end
      end
      nfa_pkg::S_RMW: begin
        state_nxt = out_free ? nfa_pkg::S_IDLE : nfa_pkg::S_POST;
      end
      nfa_pkg::S_SWEEP: begin
        if (sweep_last) state_nxt = nfa_pkg::S_POST;
      end
      nfa_pkg::S_POST: begin
        if (out_free) state_nxt = nfa_pkg::S_IDLE;
      end
      default: state_nxt = nfa_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    mem_req        = '0;
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    fill_nxt       = fill_r;
    act_nxt        = act_r;
    wdata_nxt      = wdata_r;
    waddr_nxt      = waddr_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;

    case (state_r)
      nfa_pkg::S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r[WA_W-1:0];
        mem_req.wdata = '0;
        ptr_nxt       = ptr_r + 1'b1;
      end
      nfa_pkg::S_IDLE: begin
        if (in_valid) begin
          // issue the read now; the word is back in the next cycle
          mem_req.re     = 1'b1;
          mem_req.raddr  = in_byte_address[BA_W-1:1];
          act_nxt        = in_action;
          wdata_nxt      = in_write_data;
          waddr_nxt      = in_byte_address[BA_W-1:1];
          ptr_nxt        = dec_start;
          end_nxt        = dec_end;
          fill_nxt       = nfa_pkg::ERASED_WORD;
          res_data_nxt   = '0;
          res_status_nxt = dec_status;
        end
      end
      nfa_pkg::S_RMW: begin
        res_data_nxt   = (act_r == nfa_pkg::ACT_PROGRAM) ? (mem_rdata & wdata_r) : mem_rdata;
        res_status_nxt = nfa_pkg::ST_OK;
        mem_req.we     = (act_r == nfa_pkg::ACT_PROGRAM);
        mem_req.waddr  = waddr_r;
        mem_req.wdata  = res_data_nxt;
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_nxt;
          out_status_nxt = nfa_pkg::ST_OK;
        end
      end
      nfa_pkg::S_SWEEP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r[WA_W-1:0];
        mem_req.wdata = fill_r;
        ptr_nxt       = ptr_r + 1'b1;
      end
      nfa_pkg::S_POST: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfa_pkg::S_CLEAR;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r        <= end_nxt;
    fill_r       <= fill_nxt;
    act_r        <= act_nxt;
    wdata_r      <= wdata_nxt;
    waddr_r      <= waddr_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_stall      = (state_r != nfa_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_status    = out_status_r;

endmodule

@@ tb/sv/nor_flash_reply_checker.sv @@
`timescale 1ns / 1ps
// Reply checker for the NOR flash array model: tracks the flash image and compares replies.
module nor_flash_reply_checker #(
  parameter int unsigned SECTOR_BYTES = nfa_pkg::SECTOR_BYTES_DEF,
  parameter int unsigned SECTOR_COUNT = nfa_pkg::SECTOR_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      in_action,
  input  logic [nfa_pkg::BYTE_ADDR_W-1:0] in_byte_address,
  input  logic [5:0]                      in_sector_number,
  input  logic [nfa_pkg::DATA_W-1:0]      in_write_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [nfa_pkg::DATA_W-1:0]      out_read_data,
  input  logic [1:0]                      out_status,
  output int                              fail_count,
  output int                              replies_checked,
  output int                              replies_flagged,
  output int                              replies_due
);

  typedef struct packed {
    logic [1:0]                      act;
    logic [nfa_pkg::BYTE_ADDR_W-1:0] addr;
    logic [nfa_pkg::DATA_W-1:0]      data;
    logic [1:0]                      status;
  } flash_reply_t;

  localparam longint unsigned FULL_BYTES  = 64'(SECTOR_BYTES) * 64'(SECTOR_COUNT);
  localparam longint unsigned ARRAY_BYTES =
    (FULL_BYTES > nfa_pkg::STORE_BYTES) ? nfa_pkg::STORE_BYTES : FULL_BYTES;

  logic [nfa_pkg::DATA_W-1:0] flash_image [nfa_pkg::STORE_WORDS];
  flash_reply_t               due_replies [$];
  bit                         image_cleared = 1'b0;
  int                         fails = 0;
  int                         checked = 0;
  int                         flagged = 0;

  // Set every word whose bytes fall in [lo, hi) to all ones, clipped to the store.
  function automatic void erase_span(longint unsigned lo, longint unsigned hi);
    longint unsigned w;
    if (hi > nfa_pkg::STORE_BYTES) hi = nfa_pkg::STORE_BYTES;
    for (w = lo / 2; w < hi / 2 && w < nfa_pkg::STORE_WORDS; w++)
      flash_image[w] = nfa_pkg::ERASED_WORD;
  endfunction

  // Apply one action to the image and return the reply it should produce.
  function automatic flash_reply_t flash_apply(logic [1:0] act,
                                               logic [nfa_pkg::BYTE_ADDR_W-1:0] addr,
                                               logic [5:0] sec,
                                               logic [nfa_pkg::DATA_W-1:0] wdata);
    flash_reply_t                    r;
    logic [nfa_pkg::WORD_ADDR_W-1:0] w;
    longint unsigned                 lo;
    r.act    = act;
    r.addr   = addr;
    r.data   = '0;
    r.status = nfa_pkg::ST_OK;
    w        = addr[nfa_pkg::BYTE_ADDR_W-1:1];
    case (act)
      nfa_pkg::ACT_READ, nfa_pkg::ACT_PROGRAM: begin
        if (addr[0]) begin
          r.status = nfa_pkg::ST_ODD;
        end else if (64'(addr) >= ARRAY_BYTES) begin
          r.status = nfa_pkg::ST_RANGE;
        end else begin
          if (act == nfa_pkg::ACT_PROGRAM) flash_image[w] = flash_image[w] & wdata;
          r.data = flash_image[w];
        end
      end
      nfa_pkg::ACT_ERASE_SEC: begin
        if (sec >= SECTOR_COUNT) begin
          r.status = nfa_pkg::ST_SECTOR;
        end else begin
          lo = 64'(sec) * 64'(SECTOR_BYTES);
          erase_span(lo, lo + 64'(SECTOR_BYTES));
        end
      end
      default: erase_span(0, ARRAY_BYTES);
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    flash_reply_t want;
    if (!rst_n) begin
      // the block clears its store to zeros after reset
      if (!image_cleared) begin
        foreach (flash_image[i]) flash_image[i] = '0;
        image_cleared = 1'b1;
      end
      due_replies.delete();
    end else begin
      // compare the reply first: it always belongs to an earlier transfer
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          fails++;
          $display("%0t: unexpected reply, expected none, actual data %h status %0d",
                   $time, out_read_data, out_status);
        end else begin
          want = due_replies.pop_front();
          checked++;
          if (out_status != nfa_pkg::ST_OK) flagged++;
          if (out_read_data !== want.data) begin
            fails++;
            $display("%0t: read_data mismatch (action %0d addr %h), expected %h, actual %h",
                     $time, want.act, want.addr, want.data, out_read_data);
          end
          if (out_status !== want.status) begin
            fails++;
            $display("%0t: status mismatch (action %0d addr %h), expected %0d, actual %0d",
                     $time, want.act, want.addr, want.status, out_status);
          end
        end
      end
      if (in_valid && !in_stall)
        due_replies.push_back(flash_apply(in_action, in_byte_address, in_sector_number,
                                          in_write_data));
    end
    fail_count      <= fails;
    replies_checked <= checked;
    replies_flagged <= flagged;
    replies_due     <= due_replies.size();
  end

endmodule

@@ tb/sv/tb_nor_flash_array_model_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the NOR flash array model: clock, reset, stimulus and verdict.
module tb_nor_flash_array_model_top;

  localparam int unsigned SECTOR_BYTES = nfa_pkg::SECTOR_BYTES_DEF;
  localparam int unsigned SECTOR_COUNT = nfa_pkg::SECTOR_COUNT_DEF;

  // Slowest correct run is roughly the clearing pass, one chip erase and a
  // handful of sector erases; the limit is set above it.
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int RANDOM_ITEMS  = 680;
  localparam int SECTOR_BUDGET = 3;
  localparam int POOL_SIZE     = 24;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [1:0]                      in_action = nfa_pkg::ACT_READ;
  logic [nfa_pkg::BYTE_ADDR_W-1:0] in_byte_address = '0;
  logic [5:0]                      in_sector_number = '0;
  logic [nfa_pkg::DATA_W-1:0]      in_write_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [nfa_pkg::DATA_W-1:0]      out_read_data;
  logic [1:0]                      out_status;

  int fail_count;
  int replies_checked;
  int replies_flagged;
  int replies_due;

  // Transfer counts kept by the sender
  int n_sent = 0;
  int n_reads = 0;
  int n_programs = 0;
  int n_sector_erases = 0;
  int n_real_erases = 0;
  int n_chip_erases = 0;
  int cycle_count = 0;

  // While set, neither side inserts idle cycles
  logic calm;
  assign calm = (n_sent >= 300) && (n_sent < 420);

  logic [nfa_pkg::BYTE_ADDR_W-1:0] addr_pool [POOL_SIZE];
  logic [5:0]                      pool_sectors [4] = '{6'd0, 6'd1, 6'd7, 6'd15};

  always #6 clk = ~clk;

  nor_flash_array_model_top #(
    .SECTOR_BYTES(SECTOR_BYTES),
    .SECTOR_COUNT(SECTOR_COUNT)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_byte_address (in_byte_address),
    .in_sector_number(in_sector_number),
    .in_write_data   (in_write_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_status      (out_status)
  );

  nor_flash_reply_checker #(
    .SECTOR_BYTES(SECTOR_BYTES),
    .SECTOR_COUNT(SECTOR_COUNT)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_byte_address (in_byte_address),
    .in_sector_number(in_sector_number),
    .in_write_data   (in_write_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .replies_checked (replies_checked),
    .replies_flagged (replies_flagged),
    .replies_due     (replies_due)
  );

  // Watchdog: end the run if it drags far past the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d replies still due", cycle_count, replies_due);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: drive out_stall at the falling edge. Mostly stall at random,
  // once hold off for a long stretch so the block backs up into in_stall.
  always @(negedge clk) begin
    static int  hold_left = 0;
    static bit  held_once = 1'b0;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held_once && n_sent >= 200) begin
      held_once = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 6);
    end
  end

  // Offer one item from a falling edge; hold the payload until the transfer
  // happens at a rising edge, then return at the next falling edge.
  task automatic send_item(input logic [1:0] act,
                           input logic [nfa_pkg::BYTE_ADDR_W-1:0] addr,
                           input logic [5:0] sec,
                           input logic [nfa_pkg::DATA_W-1:0] data);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_byte_address  <= addr;
    in_sector_number <= sec;
    in_write_data    <= data;
    do @(posedge clk); while (in_stall);
    n_sent++;
    case (act)
      nfa_pkg::ACT_READ:      n_reads++;
      nfa_pkg::ACT_PROGRAM:   n_programs++;
      nfa_pkg::ACT_ERASE_SEC: begin
        n_sector_erases++;
        if (sec < SECTOR_COUNT) n_real_erases++;
      end
      default:                n_chip_erases++;
    endcase
    @(negedge clk);
  endtask

  // Pick an address for a read or program: mostly the pool, so words get
  // programmed several times and read back; some odd, some anywhere.
  function automatic logic [nfa_pkg::BYTE_ADDR_W-1:0] pick_address();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return addr_pool[$urandom_range(POOL_SIZE - 1)];
    if (r < 88) return nfa_pkg::BYTE_ADDR_W'($urandom()) | 20'd1;
    return nfa_pkg::BYTE_ADDR_W'($urandom()) & ~20'd1;
  endfunction

  initial begin
    logic [1:0]                      act;
    logic [nfa_pkg::BYTE_ADDR_W-1:0] addr;
    logic [5:0]                      sec;
    logic [nfa_pkg::DATA_W-1:0]      data;
    int unsigned                     r;
    int                              erase_budget;

    erase_budget = SECTOR_BUDGET;
    foreach (addr_pool[i])
      addr_pool[i] = nfa_pkg::BYTE_ADDR_W'(pool_sectors[$urandom_range(3)] * SECTOR_BYTES
                                           + 2 * $urandom_range(SECTOR_BYTES / 2 - 1));

    // Hold reset low, then release it at a falling edge.
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The store starts as zeros, so reads and programs see
    // zero until a sector is erased. Cover the extreme addresses, odd
    // addresses, first and last sectors, bad sector numbers and a chip erase.
    send_item(nfa_pkg::ACT_READ,      20'h00000, 6'd63, 16'hFFFF);
    send_item(nfa_pkg::ACT_READ,      20'hFFFFE, 6'd0,  16'h0000);
    send_item(nfa_pkg::ACT_READ,      20'hFFFFF, 6'd0,  16'h0000);
    send_item(nfa_pkg::ACT_PROGRAM,   20'h00001, 6'd0,  16'hFFFF);
    send_item(nfa_pkg::ACT_PROGRAM,   20'h00010, 6'd0,  16'hA5A5);
    send_item(nfa_pkg::ACT_ERASE_SEC, 20'hFFFFF, 6'd0,  16'hFFFF);
    send_item(nfa_pkg::ACT_READ,      20'h00010, 6'd0,  16'h0000);
    send_item(nfa_pkg::ACT_PROGRAM,   20'h00010, 6'd0,  16'hA5A5);
    send_item(nfa_pkg::ACT_PROGRAM,   20'h00010, 6'd0,  16'h0FF0);
    send_item(nfa_pkg::ACT_PROGRAM,   20'h00000, 6'd0,  16'h0000);
    send_item(nfa_pkg::ACT_PROGRAM,   20'h0FFFE, 6'd0,  16'hFFFF);
    send_item(nfa_pkg::ACT_READ,      20'h10000, 6'd0,  16'h0000);
    send_item(nfa_pkg::ACT_ERASE_SEC, 20'h00000, 6'd15, 16'h0000);
    send_item(nfa_pkg::ACT_PROGRAM,   20'hFFFFE, 6'd0,  16'h1234);
    send_item(nfa_pkg::ACT_ERASE_SEC, 20'h00000, 6'd16, 16'h0000);
    send_item(nfa_pkg::ACT_ERASE_SEC, 20'h00000, 6'd63, 16'h0000);
    send_item(nfa_pkg::ACT_READ,      20'hFFFFE, 6'd0,  16'h0000);
    send_item(nfa_pkg::ACT_ERASE_ALL, 20'h55555, 6'd42, 16'h5A5A);
    send_item(nfa_pkg::ACT_READ,      20'h00010, 6'd0,  16'h0000);
    send_item(nfa_pkg::ACT_READ,      20'h80000, 6'd0,  16'h0000);
    send_item(nfa_pkg::ACT_PROGRAM,   20'h55554, 6'd21, 16'h5555);
    send_item(nfa_pkg::ACT_PROGRAM,   20'hAAAAA, 6'd42, 16'hAAAA);
    send_item(nfa_pkg::ACT_READ,      20'h55555, 6'd0,  16'h0000);

    // Random part: reads and programs around a pool of words, erases that
    // are mostly out of range (cheap), and a few real sector erases that
    // set pool words back to all ones.
    repeat (RANDOM_ITEMS) begin
      r    = $urandom_range(99);
      addr = nfa_pkg::BYTE_ADDR_W'($urandom());
      sec  = 6'($urandom_range(63));
      data = nfa_pkg::DATA_W'($urandom());
      if (r < 42) begin
        act  = nfa_pkg::ACT_READ;
        addr = pick_address();
      end else if (r < 84) begin
        act  = nfa_pkg::ACT_PROGRAM;
        addr = pick_address();
        // clear only one bit half the time so words wear down slowly
        if ($urandom_range(1) == 0)
          data = ~(nfa_pkg::DATA_W'(1) << $urandom_range(nfa_pkg::DATA_W - 1));
      end else begin
        act = nfa_pkg::ACT_ERASE_SEC;
        if (erase_budget > 0 && $urandom_range(29) == 0) begin
          erase_budget--;
          sec = pool_sectors[$urandom_range(3)];
        end else begin
          sec = 6'($urandom_range(63, SECTOR_COUNT));
        end
      end
      send_item(act, addr, sec, data);
    end
    in_valid <= 1'b0;

    // Drain: wait for every reply, then keep watching for stray replies.
    while (replies_checked != n_sent) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d reads, %0d programs, %0d sector erases (%0d in range), %0d chip erases",
             n_reads, n_programs, n_sector_erases, n_real_erases, n_chip_erases);
    $display("Compared %0d replies, %0d flagged, %0d mismatches, in %0d cycles",
             replies_checked, replies_flagged, fail_count, cycle_count);
    if (fail_count == 0 && replies_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/nfa_pkg.sv
design/nfa_mem.sv
design/nfa_ctrl.sv
design/nor_flash_array_model_top.sv
tb/sv/nor_flash_reply_checker.sv
tb/sv/tb_nor_flash_array_model_top.sv
